/* design/triangle_level_slicer_defines.svh */
// assertion macros for the triangle level slicer
// used by tls_queue to check its own control logic
`ifndef TRIANGLE_LEVEL_SLICER_DEFINES_SVH
`define TRIANGLE_LEVEL_SLICER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TLS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tls assertion failed");
`define TLS_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("tls forbidden condition");
`else
`define TLS_ASSERT(label, clk, rst, prop)
`define TLS_NEVER(label, clk, rst, expr)
`endif
`endif

/* design/tls_pkg.sv */
// shared types, constants and tables of the triangle level slicer
// no dependencies
package tls_pkg;

  localparam int MAX_LEVELS = 64;
  localparam int SW = 51;   // projection width, 32 fraction bits
  localparam int LW = 39;   // level offset width, 16 fraction bits
  localparam int DW = 56;   // difference to cutting line
  localparam int QW = 52;   // projection difference

  localparam logic [1:0] SKIP = 2'd3;

  typedef enum logic [2:0] {
    REG_DIR_SINE     = 3'd0,
    REG_DIR_COSINE   = 3'd1,
    REG_FIRST_LEVEL  = 3'd2,
    REG_LEVEL_SPACING = 3'd3,
    REG_LEVEL_COUNT  = 3'd4
  } reg_index_t;

  localparam logic [1:0] LONE_TABLE [27] = '{
    SKIP, 2'd2, 2'd2,  2'd1, 2'd0, 2'd0,  2'd1, 2'd0, 2'd0,
    2'd0, 2'd1, 2'd1,  2'd2, SKIP, 2'd2,  2'd1, 2'd1, 2'd0,
    2'd0, 2'd1, 2'd1,  2'd0, 2'd0, 2'd1,  2'd2, 2'd2, SKIP
  };

  typedef struct packed {
    logic signed [17:0] dir_sine;
    logic signed [17:0] dir_cosine;
    logic signed [31:0] first_level;
    logic [30:0]        level_spacing;
    logic [6:0]         level_count;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_h;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_h;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_h;
  } tri_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_h;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_h;
    logic [5:0]         level_index;
    logic               last_segment;
  } seg_t;

  typedef struct packed {
    logic signed [31:0]   lx, ly, lh;
    logic signed [31:0]   px, py, ph;
    logic signed [31:0]   qx, qy, qh;
    logic signed [DW-1:0] num;
    logic signed [SW-1:0] sl, sp, sq;
    logic [5:0]           level;
    logic                 last;
  } job_t;

  function automatic logic [1:0] lone_vertex(input logic [4:0] idx);
    logic [1:0] k;
    k = (idx < 5'd27) ? LONE_TABLE[idx] : SKIP;
    return k;
  endfunction

endpackage

/* design/tls_tri_if.sv */
// input channel carrying one triangle per item
// depends on tls_pkg
interface tls_tri_if;
  import tls_pkg::*;
  logic valid;
  logic ready;
  tri_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/tls_seg_if.sv */
// output channel carrying one segment per item
// depends on tls_pkg
interface tls_seg_if;
  import tls_pkg::*;
  logic valid;
  logic ready;
  seg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/tls_queue.sv */
// two-entry job queue between the classifier and the segment builder
// depends on tls_pkg and the assertion macro header
`include "triangle_level_slicer_defines.svh"
module tls_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tls_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tls_pkg::job_t pop_job
);
  import tls_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  `TLS_NEVER(a_count_range, clk, rst, count == 2'd3)
  `TLS_ASSERT(a_push_grows, clk, rst, (push && !pop) |=> count == $past(count) + 2'd1)
  `TLS_ASSERT(a_ptr_gap, clk, rst, (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)

endmodule

/* design/tls_front.sv */
// classifier: projects a triangle and walks the cutting lines, one job per crossing
// depends on tls_pkg and tls_tri_if
module tls_front (
  input  logic          clk,
  input  logic          rst,
  input  tls_pkg::cfg_t cfg,
  tls_tri_if.sink       tri_in,
  output logic          push_valid,
  input  logic          push_ready,
  output tls_pkg::job_t push_job
);
  import tls_pkg::*;

  typedef enum logic [2:0] {IDLE, MUL, SUM, DIFF, CLASS, FLUSH} state_t;

  state_t                 state;
  logic signed [31:0]     vx [3];
  logic signed [31:0]     vy [3];
  logic signed [31:0]     vh [3];
  logic signed [49:0]     prod_x [3];
  logic signed [49:0]     prod_y [3];
  logic signed [SW-1:0]   s [3];
  logic signed [DW-1:0]   d [3];
  logic signed [LW-1:0]   level;
  logic [6:0]             lvl;
  logic [6:0]             count;
  job_t                   pend;
  logic                   pend_valid;
  logic [1:0]             code [3];
  logic [4:0]             idx;
  logic [1:0]             k;
  job_t                   job_new;
  logic                   stall;

  assign tri_in.ready = (state == IDLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      code[i] = d[i][DW-1] ? 2'd0 : ((d[i] == '0) ? 2'd1 : 2'd2);
    end
    idx = 5'(code[0]) * 5'd9 + 5'(code[1]) * 5'd3 + 5'(code[2]);
    k = lone_vertex(idx);
    job_new = pend;
    job_new.level = lvl[5:0];
    job_new.last  = 1'b0;
    unique case (k)
      2'd0: begin
        job_new.lx = vx[0]; job_new.ly = vy[0]; job_new.lh = vh[0];
        job_new.px = vx[1]; job_new.py = vy[1]; job_new.ph = vh[1];
        job_new.qx = vx[2]; job_new.qy = vy[2]; job_new.qh = vh[2];
        job_new.num = d[0];
        job_new.sl = s[0]; job_new.sp = s[1]; job_new.sq = s[2];
      end
      2'd1: begin
        job_new.lx = vx[1]; job_new.ly = vy[1]; job_new.lh = vh[1];
        job_new.px = vx[2]; job_new.py = vy[2]; job_new.ph = vh[2];
        job_new.qx = vx[0]; job_new.qy = vy[0]; job_new.qh = vh[0];
        job_new.num = d[1];
        job_new.sl = s[1]; job_new.sp = s[2]; job_new.sq = s[0];
      end
      default: begin
        job_new.lx = vx[2]; job_new.ly = vy[2]; job_new.lh = vh[2];
        job_new.px = vx[0]; job_new.py = vy[0]; job_new.ph = vh[0];
        job_new.qx = vx[1]; job_new.qy = vy[1]; job_new.qh = vh[1];
        job_new.num = d[2];
        job_new.sl = s[2]; job_new.sp = s[0]; job_new.sq = s[1];
      end
    endcase

    push_job = pend;
    push_valid = 1'b0;
    if (state == CLASS) begin
      push_valid = (k != SKIP) && pend_valid;
      push_job.last = 1'b0;
    end else if (state == FLUSH) begin
      push_valid = pend_valid;
      push_job.last = 1'b1;
    end
    stall = push_valid && !push_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (tri_in.valid) begin
            vx[0] <= tri_in.data.a_x; vy[0] <= tri_in.data.a_y; vh[0] <= tri_in.data.a_h;
            vx[1] <= tri_in.data.b_x; vy[1] <= tri_in.data.b_y; vh[1] <= tri_in.data.b_h;
            vx[2] <= tri_in.data.c_x; vy[2] <= tri_in.data.c_y; vh[2] <= tri_in.data.c_h;
            count <= (cfg.level_count > 7'(MAX_LEVELS)) ? 7'(MAX_LEVELS) : cfg.level_count;
            level <= LW'(cfg.first_level);
            lvl   <= 7'd0;
            state <= MUL;
          end
        end
        MUL: begin
          for (int i = 0; i < 3; i++) begin
            prod_x[i] <= cfg.dir_sine * vx[i];
            prod_y[i] <= cfg.dir_cosine * vy[i];
          end
          state <= SUM;
        end
        SUM: begin
          for (int i = 0; i < 3; i++) begin
            s[i] <= SW'(prod_y[i]) - SW'(prod_x[i]);
          end
          state <= (count == 7'd0) ? IDLE : DIFF;
        end
        DIFF: begin
          for (int i = 0; i < 3; i++) begin
            d[i] <= DW'(s[i]) - DW'($signed({level, 16'b0}));
          end
          state <= CLASS;
        end
        CLASS: begin
          if (!stall) begin
            if (k != SKIP) begin
              pend       <= job_new;
              pend_valid <= 1'b1;
            end
            level <= level + LW'(cfg.level_spacing);
            lvl   <= lvl + 7'd1;
            state <= (lvl + 7'd1 == count) ? FLUSH : DIFF;
          end
        end
        FLUSH: begin
          if (!stall) begin
            pend_valid <= 1'b0;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* design/tls_back.sv */
// segment builder: two restoring dividers and a shared interpolator per job
// depends on tls_pkg and tls_seg_if
module tls_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  tls_pkg::job_t pop_job,
  tls_seg_if.source     seg_out
);
  import tls_pkg::*;

  typedef enum logic [2:0] {IDLE, PREP, CHECK, DIV, SUBC, MULC, ADDC, OUT} state_t;

  state_t                state;
  job_t                  job;
  logic [DW-1:0]         an;
  logic [QW-1:0]         ad0, ad1;
  logic                  zero0, zero1, sat0, sat1;
  logic [QW:0]           rem0, rem1;
  logic [31:0]           q0, q1;
  logic [4:0]            bit_cnt;
  logic [2:0]            ci;
  logic signed [32:0]    diff_r;
  logic signed [50:0]    hi_r;
  logic signed [50:0]    lo_r;
  logic signed [31:0]    res [6];

  logic signed [QW-1:0]  den0, den1;
  logic [QW:0]           sh0, sh1;
  logic [32:0]           t0, t1, t_sel;
  logic signed [31:0]    from_c, to_c;
  logic signed [50:0]    qsum;
  logic signed [34:0]    rsum;

  assign pop_ready = (state == IDLE);

  always_comb begin
    den0 = QW'(job.sl) - QW'(job.sp);
    den1 = QW'(job.sl) - QW'(job.sq);
    sh0 = {rem0[QW-1:0], 1'b0};
    sh1 = {rem1[QW-1:0], 1'b0};
    t0 = zero0 ? 33'd0 : (sat0 ? {1'b1, 32'd0} : {1'b0, q0});
    t1 = zero1 ? 33'd0 : (sat1 ? {1'b1, 32'd0} : {1'b0, q1});
    t_sel = (ci < 3'd3) ? t0 : t1;
    case (ci)
      3'd0: begin from_c = job.lx; to_c = job.px; end
      3'd1: begin from_c = job.ly; to_c = job.py; end
      3'd2: begin from_c = job.lh; to_c = job.ph; end
      3'd3: begin from_c = job.lx; to_c = job.qx; end
      3'd4: begin from_c = job.ly; to_c = job.qy; end
      default: begin from_c = job.lh; to_c = job.qh; end
    endcase
    qsum = hi_r + (lo_r >>> 16);
    rsum = 35'(from_c) + 35'((qsum + 51'sd32768) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      seg_out.valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (pop_valid) begin
            job   <= pop_job;
            state <= PREP;
          end
        end
        PREP: begin
          zero0 <= (den0 == '0) || (job.num != '0 && job.num[DW-1] != den0[QW-1]);
          zero1 <= (den1 == '0) || (job.num != '0 && job.num[DW-1] != den1[QW-1]);
          an  <= job.num[DW-1] ? DW'(-job.num) : DW'(job.num);
          ad0 <= den0[QW-1] ? QW'(-den0) : QW'(den0);
          ad1 <= den1[QW-1] ? QW'(-den1) : QW'(den1);
          state <= CHECK;
        end
        CHECK: begin
          sat0 <= an >= DW'(ad0);
          sat1 <= an >= DW'(ad1);
          rem0 <= {1'b0, an[QW-1:0]};
          rem1 <= {1'b0, an[QW-1:0]};
          bit_cnt <= 5'd0;
          state <= DIV;
        end
        DIV: begin
          if (sh0 >= {1'b0, ad0}) begin
            rem0 <= sh0 - {1'b0, ad0};
            q0   <= {q0[30:0], 1'b1};
          end else begin
            rem0 <= sh0;
            q0   <= {q0[30:0], 1'b0};
          end
          if (sh1 >= {1'b0, ad1}) begin
            rem1 <= sh1 - {1'b0, ad1};
            q1   <= {q1[30:0], 1'b1};
          end else begin
            rem1 <= sh1;
            q1   <= {q1[30:0], 1'b0};
          end
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd31) begin
            ci    <= 3'd0;
            state <= SUBC;
          end
        end
        SUBC: begin
          diff_r <= 33'(to_c) - 33'(from_c);
          state  <= MULC;
        end
        MULC: begin
          hi_r  <= diff_r * $signed({1'b0, t_sel[32:16]});
          lo_r  <= 51'(diff_r * $signed({1'b0, t_sel[15:0]}));
          state <= ADDC;
        end
        ADDC: begin
          res[ci] <= rsum[31:0];
          if (ci == 3'd5) begin
            seg_out.valid <= 1'b1;
            state <= OUT;
          end else begin
            ci    <= ci + 3'd1;
            state <= SUBC;
          end
        end
        OUT: begin
          if (seg_out.ready) begin
            seg_out.valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    seg_out.data.start_x      = res[0];
    seg_out.data.start_y      = res[1];
    seg_out.data.start_h      = res[2];
    seg_out.data.end_x        = res[3];
    seg_out.data.end_y        = res[4];
    seg_out.data.end_h        = res[5];
    seg_out.data.level_index  = job.level;
    seg_out.data.last_segment = job.last;
  end

endmodule

/* design/triangle_level_slicer.sv */
// Triangle level slicer. Each input item is one triangle; for every cutting
// line it crosses, one segment item leaves, in level order, the final one
// marked last. On the classifier side, setup projects the triangle, then each
// level in use is visited in turn and the last job is flushed. The builder
// forms each segment with the 32-step restoring dividers and the single shared
// interpolation multiplier pair; a two-entry queue lets both sides run
// concurrently. Configuration writes are taken at any edge with cfg_we high.
module triangle_level_slicer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  tls_tri_if.sink     tri_in,
  tls_seg_if.source   seg_out
);
  import tls_pkg::*;

  cfg_t cfg;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir_sine      <= 18'sd0;
      cfg.dir_cosine    <= 18'sd65536;
      cfg.first_level   <= 32'sd0;
      cfg.level_spacing <= 31'd65536;
      cfg.level_count   <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIR_SINE:      cfg.dir_sine      <= cfg_data[17:0];
        REG_DIR_COSINE:    cfg.dir_cosine    <= cfg_data[17:0];
        REG_FIRST_LEVEL:   cfg.first_level   <= cfg_data;
        REG_LEVEL_SPACING: cfg.level_spacing <= cfg_data[30:0];
        REG_LEVEL_COUNT:   cfg.level_count   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  tls_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .tri_in(tri_in),
    .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job)
  );

  tls_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_job(pop_job)
  );

  tls_back u_back (
    .clk(clk), .rst(rst),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_job(pop_job),
    .seg_out(seg_out)
  );

endmodule
